// ===== sv/prd_pkg.sv =====
// ----------------------------------------------------------------------------
// prd_pkg
// Shared types and constants of the polyphase run distributor.
// ----------------------------------------------------------------------------
package prd_pkg;

	localparam int TAPES_DEF = 8;
	localparam int TAPES_MIN = 3;
	localparam int CFG_W     = 4;
	localparam int VAL_W     = 32;
	localparam int CNT_W     = 32;
	localparam int LEVEL_W   = 16;
	localparam int TAPE_W    = 3;

	localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;
	localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

	localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;
	localparam logic [CNT_W-1:0]   DROP_MAX  = '1;
	localparam logic [CFG_W-1:0]   TAPES_RST = CFG_W'(TAPES_MIN);

	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [CFG_W-1:0] cfg_t;

	typedef enum logic {
		KIND_DATA = 1'b0,
		KIND_END  = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t                    kind;
		logic signed [VAL_W-1:0]  value;
	} item_t;

	typedef struct packed {
		logic [TAPE_W-1:0]        tape;
		logic signed [VAL_W-1:0]  value_res;
		logic                     is_run_end;
		logic [LEVEL_W-1:0]       level;
		logic [CNT_W-1:0]         sentinel_count;
		logic                     last;
	} result_t;

endpackage

// ===== sv/prd_stream_if.sv =====
// ----------------------------------------------------------------------------
// prd_stream_if
// Valid/ready channel carrying one payload of a given type.
// ----------------------------------------------------------------------------
interface prd_stream_if #(
	parameter type payload_t = logic
) ();

	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);

endinterface

// ===== sv/prd_select.sv =====
// ----------------------------------------------------------------------------
// prd_select
// Next-tape selection: consume one dummy run on the current tape, pick the
// next tape and raise the level with the generalized Fibonacci update.
// ----------------------------------------------------------------------------
module prd_select import prd_pkg::*; #(
	parameter int TAPES = TAPES_DEF,
	localparam int TW   = $clog2(TAPES),
	localparam int NW   = TW + 1
) (
	input  logic [NW-1:0]      n,
	input  logic [TW-1:0]      cur,
	input  cnt_t               ideal [TAPES],
	input  cnt_t               dummy [TAPES],
	input  logic [LEVEL_W-1:0] level,
	output logic [TW-1:0]      cur_nxt,
	output cnt_t               ideal_nxt [TAPES],
	output cnt_t               dummy_nxt [TAPES],
	output logic [LEVEL_W-1:0] level_nxt
);

	logic [NW-1:0] i_inc;
	logic          nxt_ok;
	logic [TW-1:0] nxt_idx;
	cnt_t          dec;
	cnt_t          base;
	logic          advance;
	logic          raise;

	always_comb begin
		i_inc   = {1'b0, cur} + NW'(1);
		nxt_ok  = i_inc < n;
		nxt_idx = nxt_ok ? i_inc[TW-1:0] : '0;
		dec     = dummy[cur] - cnt_t'(1);
		base    = ideal[0];
		advance = nxt_ok && ($signed(dec) < $signed(dummy[nxt_idx]));
		raise   = !advance && (dec == '0);
		cur_nxt = advance ? nxt_idx : '0;

		if (raise && level != LEVEL_MAX) begin
			level_nxt = level + LEVEL_W'(1);
		end else begin
			level_nxt = level;
		end

		for (int k = 0; k < TAPES; k++) begin
			if (raise && (NW'(k + 1) < n)) begin
				dummy_nxt[k] = ideal[(k + 1) % TAPES] - ideal[k] + base;
				ideal_nxt[k] = ideal[(k + 1) % TAPES] + base;
			end else begin
				dummy_nxt[k] = (TW'(k) == cur) ? dec : dummy[k];
				ideal_nxt[k] = ideal[k];
			end
		end
	end

endmodule

// ===== sv/polyphase_run_distributor_top.sv =====
// ----------------------------------------------------------------------------
// polyphase_run_distributor_top
// Cuts a stream of signed numbers into ascending runs and deals the runs
// out to tapes by polyphase distribution.
// ----------------------------------------------------------------------------
// Channels: cfg writes the tape count (restarts the distribution), item takes
// a data number or an end marker, result gives the tape writes in order.
// A request on item is registered in the input register, worked out once the
// result buffer has room, and its results land in a two-entry result buffer.
// Throughput: one item per cycle while no run breaks and the receiver takes
// every result; a run break yields a terminator and the number, so the next
// item waits until the buffer has room for both of them.
// A maximum value is counted and yields no result. An end item yields the
// final terminator and returns all state, the tape count included, to reset.
// Reset sets every counter at once: tapes 0..1 hold one ideal and one
// dummy run, the level is 1, the tape count is 3.
// When the receiver stalls, results wait in the buffer; one more item waits
// in the input register, then item.ready drops.
// ----------------------------------------------------------------------------
module polyphase_run_distributor_top import prd_pkg::*; #(
	parameter int TAPES = TAPES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	prd_stream_if.sink   cfg,
	prd_stream_if.sink   item,
	prd_stream_if.source result
);

	localparam int TW = $clog2(TAPES);
	localparam int NW = TW + 1;

	function automatic logic [NW-1:0] clamp_tapes(input cfg_t raw);
		logic [NW-1:0] r;
		if (int'(raw) < TAPES_MIN) begin
			r = NW'(TAPES_MIN);
		end else if (int'(raw) > TAPES) begin
			r = NW'(TAPES);
		end else begin
			r = NW'(raw);
		end
		return r;
	endfunction

	// state
	cfg_t                    tapes_q;
	logic [TW-1:0]           cur_q;
	logic signed [VAL_W-1:0] prev_q;
	cnt_t                    ideal_q [TAPES];
	cnt_t                    dummy_q [TAPES];
	logic [LEVEL_W-1:0]      level_q;
	cnt_t                    drop_q;

	// input register and result buffer
	item_t                   item_s1;
	logic                    item_vld_s1;
	result_t                 res_q [2];
	logic [1:0]              res_cnt_q;

	logic                    cfg_fire;
	logic                    pop;
	logic                    proc;
	logic                    is_end;
	logic                    is_max;
	logic                    is_brk;
	logic [NW-1:0]           n_cur;
	logic [NW-1:0]           rst_n_sel;
	cnt_t                    rst_cnt [TAPES];
	logic [TW-1:0]           sel_cur;
	cnt_t                    sel_ideal [TAPES];
	cnt_t                    sel_dummy [TAPES];
	logic [LEVEL_W-1:0]      sel_level;
	result_t                 r0;
	result_t                 r1;
	logic [1:0]              nres;

	assign cfg_fire      = cfg.valid && cfg.ready;
	assign cfg.ready     = 1'b1;
	assign pop           = result.valid && result.ready;
	assign result.valid  = res_cnt_q != 2'd0;
	assign result.payload = res_q[0];
	assign proc          = item_vld_s1 && (res_cnt_q == 2'd0 || (res_cnt_q == 2'd1 && pop));
	assign item.ready    = !item_vld_s1 || proc;

	assign n_cur  = clamp_tapes(tapes_q);
	assign is_end = item_s1.kind == KIND_END;
	assign is_max = !is_end && ($signed(item_s1.value) == VAL_MAX);
	assign is_brk = !is_end && !is_max && ($signed(item_s1.value) < prev_q);

	// restart counts for a new tape count, or for the default after an end item
	always_comb begin
		rst_n_sel = cfg_fire ? clamp_tapes(cfg.payload) : clamp_tapes(TAPES_RST);
		for (int k = 0; k < TAPES; k++) begin
			rst_cnt[k] = (NW'(k + 1) < rst_n_sel) ? cnt_t'(1) : '0;
		end
	end

	prd_select #(
		.TAPES (TAPES)
	) u_select (
		.n         (n_cur),
		.cur       (cur_q),
		.ideal     (ideal_q),
		.dummy     (dummy_q),
		.level     (level_q),
		.cur_nxt   (sel_cur),
		.ideal_nxt (sel_ideal),
		.dummy_nxt (sel_dummy),
		.level_nxt (sel_level)
	);

	always_comb begin
		r0 = '{tape: TAPE_W'(cur_q), value_res: item_s1.value, is_run_end: 1'b0,
			level: level_q, sentinel_count: drop_q, last: 1'b1};
		r1 = r0;
		nres = 2'd1;
		if (is_end) begin
			r0.value_res  = VAL_MAX;
			r0.is_run_end = 1'b1;
			r0.level      = sel_level;
		end else if (is_max) begin
			nres = 2'd0;
		end else if (is_brk) begin
			// terminator on the old tape, then the number on the new one
			r0.value_res  = VAL_MAX;
			r0.is_run_end = 1'b1;
			r0.level      = sel_level;
			r0.last       = 1'b0;
			r1.tape       = TAPE_W'(sel_cur);
			r1.level      = sel_level;
			nres          = 2'd2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tapes_q <= TAPES_RST;
			cur_q   <= '0;
			prev_q  <= VAL_MIN;
			level_q <= LEVEL_W'(1);
			drop_q  <= '0;
			for (int k = 0; k < TAPES; k++) begin
				ideal_q[k] <= (k + 1 < TAPES_MIN) ? cnt_t'(1) : '0;
				dummy_q[k] <= (k + 1 < TAPES_MIN) ? cnt_t'(1) : '0;
			end
		end else if (cfg_fire || (proc && is_end)) begin
			tapes_q <= cfg_fire ? cfg.payload : TAPES_RST;
			cur_q   <= '0;
			prev_q  <= VAL_MIN;
			level_q <= LEVEL_W'(1);
			drop_q  <= '0;
			ideal_q <= rst_cnt;
			dummy_q <= rst_cnt;
		end else if (proc) begin
			if (is_max) begin
				if (drop_q != DROP_MAX) begin
					drop_q <= drop_q + cnt_t'(1);
				end
			end else if (is_brk) begin
				cur_q   <= sel_cur;
				ideal_q <= sel_ideal;
				dummy_q <= sel_dummy;
				level_q <= sel_level;
				prev_q  <= item_s1.value;
			end else begin
				prev_q  <= item_s1.value;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_vld_s1 <= 1'b0;
			res_cnt_q   <= 2'd0;
		end else begin
			if (item.valid && item.ready) begin
				item_vld_s1 <= 1'b1;
			end else if (proc) begin
				item_vld_s1 <= 1'b0;
			end
			if (proc) begin
				res_cnt_q <= nres;
			end else if (pop) begin
				res_cnt_q <= res_cnt_q - 2'd1;
			end
		end
	end

	// payload: a new item always lands in an emptied buffer
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= item.payload;
		end
		if (proc) begin
			res_q[0] <= r0;
			res_q[1] <= r1;
		end else if (pop) begin
			res_q[0] <= res_q[1];
		end
	end

`ifndef NO_ASSERTIONS
	a_buf_depth: assert property (@(posedge clk) disable iff (!arst_n)
		res_cnt_q != 2'd3)
		else $error("result buffer count out of range");

	a_tape_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, cur_q} < n_cur)
		else $error("current tape beyond tape count");

	a_end_restart: assert property (@(posedge clk) disable iff (!arst_n)
		proc && is_end && !cfg_fire |=> cur_q == '0 && level_q == LEVEL_W'(1) &&
			tapes_q == TAPES_RST && drop_q == '0)
		else $error("end item did not restart the distribution");

	a_item_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_vld_s1 && !proc |=> item_vld_s1)
		else $error("pending item lost without processing");
`endif

endmodule
